// File: rtl/nsst_pkg.sv
// Shared types and constants for the sorted score table.
// Holds the request, response and table entry word formats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsst_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // fixed field widths of the words
   localparam int KIND_W   = 2;
   localparam int SCORE_W  = 32;
   localparam int TAG_W    = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          in_tag;
      logic [INDEX_W-1:0]        index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [POS_W-1:0]          position;
      logic signed [SCORE_W-1:0] out_score;
      logic [TAG_W-1:0]          out_tag;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/top_n_sorted_score_table.sv
// Top level of the sorted score table: request decode, table memory and sequencer.
// Depends on nsst_pkg for word formats, codes and the table depth.
// Single module; the table is one synchronous memory of score and tag pairs.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to TABLE_DEPTH score and tag entries sorted from highest to lowest
// score in one single-port-write memory with a registered read. One operation
// is worked at a time and each returns exactly one response word. An insert
// walks the table from the bottom upward, moving each lower entry down one
// place per cycle until its slot is found. On a full table the last entry is
// checked first, and the new score is dropped when it is below that entry.
// A delete pulls each later entry up one place and a clear writes over the
// valid entries; each operation may then wait for the output register to
// drain. The table memory write port takes one entry per cycle. A new
// request is taken as soon as the sequencer is idle, even while the last
// response still waits in the output register. No clearing pass is needed.
module top_n_sorted_score_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire nsst_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      nsst_pkg::rsp_type rsp_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_INS_FULL  = 3'd1;
   localparam logic [2:0] ST_INS_SHIFT = 3'd2;
   localparam logic [2:0] ST_DEL_SHIFT = 3'd3;
   localparam logic [2:0] ST_RD_WAIT   = 3'd4;
   localparam logic [2:0] ST_CLR       = 3'd5;
   localparam logic [2:0] ST_DONE      = 3'd6;

   logic [2:0]                     state_ff, state_in;
   nsst_pkg::req_type              op_ff, op_in;
   logic [nsst_pkg::IDX_W-1:0]     ptr_ff, ptr_in;
   logic [nsst_pkg::CNT_W-1:0]     count_ff, count_in;
   nsst_pkg::rsp_type              res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   nsst_pkg::rsp_type              rsp_ff, rsp_in;

   // table memory
   nsst_pkg::entry_type            mem_ff [nsst_pkg::TABLE_DEPTH];
   nsst_pkg::entry_type            rd_data_ff;
   logic                           mem_we;
   logic [nsst_pkg::IDX_W-1:0]     mem_waddr;
   nsst_pkg::entry_type            mem_wdata;
   logic [nsst_pkg::IDX_W-1:0]     mem_raddr;

   logic                           out_free;
   logic                           req_in_range;
   logic                           op_in_range;
   nsst_pkg::entry_type            new_entry;
   logic                           new_ge_rd;
   logic [nsst_pkg::CNT_W-1:0]     ptr_next_cnt;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // index range checks against the current fill
   assign req_in_range = (32'(req_data.index) < 32'(count_ff));
   assign op_in_range  = (32'(op_ff.index) < 32'(count_ff));

   assign new_entry.score = op_ff.score;
   assign new_entry.tag   = op_ff.in_tag;
   assign new_ge_rd       = (op_ff.score >= rd_data_ff.score);
   assign ptr_next_cnt    = nsst_pkg::CNT_W'(ptr_ff) + nsst_pkg::CNT_W'(1);

   // memory write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[mem_raddr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = new_entry;
      mem_raddr    = ptr_ff;

      // response register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_data;
               res_in = '0;
               unique case (req_data.kind)
                  nsst_pkg::KIND_INSERT: begin
                     if (32'(count_ff) == nsst_pkg::TABLE_DEPTH) begin
                        // full: check the last entry first
                        mem_raddr = nsst_pkg::IDX_W'(nsst_pkg::TABLE_DEPTH - 1);
                        state_in  = ST_INS_FULL;
                     end else begin
                        ptr_in    = nsst_pkg::IDX_W'(count_ff);
                        mem_raddr = nsst_pkg::IDX_W'(count_ff - nsst_pkg::CNT_W'(1));
                        state_in  = ST_INS_SHIFT;
                     end
                  end
                  nsst_pkg::KIND_DELETE: begin
                     if (req_in_range) begin
                        ptr_in    = nsst_pkg::IDX_W'(req_data.index);
                        mem_raddr = nsst_pkg::IDX_W'(req_data.index)
                                    + nsst_pkg::IDX_W'(1);
                        state_in  = ST_DEL_SHIFT;
                     end else begin
                        res_in.status = nsst_pkg::STATUS_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  nsst_pkg::KIND_READ: begin
                     if (req_in_range) begin
                        mem_raddr = nsst_pkg::IDX_W'(req_data.index);
                        state_in  = ST_RD_WAIT;
                     end else begin
                        res_in.status = nsst_pkg::STATUS_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  nsst_pkg::KIND_CLEAR: begin
                     ptr_in = '0;
                     if (count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_CLR;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_INS_FULL: begin
            // new score below the last entry is dropped
            if (!new_ge_rd) begin
               res_in.status = nsst_pkg::STATUS_FULL;
               state_in      = ST_DONE;
            end else begin
               ptr_in    = nsst_pkg::IDX_W'(nsst_pkg::TABLE_DEPTH - 1);
               mem_raddr = nsst_pkg::IDX_W'(nsst_pkg::TABLE_DEPTH - 2);
               state_in  = ST_INS_SHIFT;
            end
         end

         ST_INS_SHIFT: begin
            // read data holds the entry just above the slot at ptr
            mem_we = 1'b1;
            if (ptr_ff != '0 && new_ge_rd) begin
               mem_wdata = rd_data_ff;
               ptr_in    = ptr_ff - nsst_pkg::IDX_W'(1);
               mem_raddr = ptr_ff - nsst_pkg::IDX_W'(2);
            end else begin
               mem_wdata       = new_entry;
               res_in.position = nsst_pkg::POS_W'(ptr_ff);
               if (32'(count_ff) < nsst_pkg::TABLE_DEPTH) begin
                  count_in = count_ff + nsst_pkg::CNT_W'(1);
               end
               state_in = ST_DONE;
            end
         end

         ST_DEL_SHIFT: begin
            // pull the next entry up over ptr
            if (ptr_next_cnt < count_ff) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff;
               ptr_in    = ptr_ff + nsst_pkg::IDX_W'(1);
               mem_raddr = ptr_ff + nsst_pkg::IDX_W'(2);
            end else begin
               count_in        = count_ff - nsst_pkg::CNT_W'(1);
               res_in.position = nsst_pkg::POS_W'(op_ff.index);
               state_in        = ST_DONE;
            end
         end

         ST_RD_WAIT: begin
            if (op_in_range) begin
               res_in.position  = nsst_pkg::POS_W'(op_ff.index);
               res_in.out_score = rd_data_ff.score;
               res_in.out_tag   = rd_data_ff.tag;
            end
            state_in = ST_DONE;
         end

         ST_CLR: begin
            // one entry per cycle over the valid part
            mem_we          = 1'b1;
            mem_wdata.score = '0;
            mem_wdata.tag   = op_ff.in_tag;
            if (ptr_next_cnt >= count_ff) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + nsst_pkg::IDX_W'(1);
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = res_ff;
               rsp_in.entry_count = nsst_pkg::COUNT_W'(count_ff);
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      ptr_ff <= ptr_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire
